### hdl/ipv6_tcp_header_locator_defines.svh
// ----------------------------------------------------------------------------
// IPv6 TCP header locator: assertion macros
// Shared assertion forms, clocked on i_clk and quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IPV6_TCP_HEADER_LOCATOR_DEFINES_SVH
`define IPV6_TCP_HEADER_LOCATOR_DEFINES_SVH

// Same-cycle implication
`define I6TCP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define I6TCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/i6tcp_pkg.sv
// ----------------------------------------------------------------------------
// IPv6 TCP header locator package
// Transaction types, status codes, header type numbers and fixed offsets.
// ----------------------------------------------------------------------------
`default_nettype none

package i6tcp_pkg;

    // Widths of header positions and of one extension header span
    localparam int HDR_BITS = 17;
    localparam int EXT_BITS = 12;

    typedef logic [HDR_BITS-1:0] t_pos;
    typedef logic [EXT_BITS-1:0] t_ext;

    // Fixed header layout
    localparam int FIXED_HDR_BYTES = 40;
    localparam int POS_LEN_HI      = 4;
    localparam int POS_LEN_LO      = 5;
    localparam int POS_NEXT_HDR    = 6;
    localparam int POS_HOP_LIMIT   = 7;
    localparam int POS_SRC_FIRST   = 8;
    localparam int POS_SRC_SPLIT   = 16;
    localparam int POS_DST_FIRST   = 24;
    localparam int POS_DST_SPLIT   = 32;

    // Offsets inside a header
    localparam int REL_NEXT_HDR   = 0;
    localparam int REL_LENGTH     = 1;
    localparam int REL_FRAG_HI    = 2;
    localparam int REL_FRAG_LO    = 3;
    localparam int REL_TCP_OFFSET = 12;

    // Minimum sizes
    localparam int TCP_MIN_BYTES  = 20;
    localparam int EXT_MIN_BYTES  = 2;
    localparam int FRAG_BYTES     = 8;

    // Next-header numbers
    localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
    localparam logic [7:0] NH_TCP        = 8'd6;
    localparam logic [7:0] NH_ROUTING    = 8'd43;
    localparam logic [7:0] NH_FRAGMENT   = 8'd44;
    localparam logic [7:0] NH_AUTH       = 8'd51;
    localparam logic [7:0] NH_DEST_OPTS  = 8'd60;

    // Fragment offset and more-fragments bits
    localparam logic [15:0] FRAG_REFUSE_MASK = 16'hFFF9;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_SHORT      = 4'd1,
        ST_TRUNCATED  = 4'd2,
        ST_EXT_LEN    = 4'd3,
        ST_FRAG_LEN   = 4'd4,
        ST_FRAGMENTED = 4'd5,
        ST_AUTH_LEN   = 4'd6,
        ST_NOT_TCP    = 4'd7,
        ST_TCP_SHORT  = 4'd8,
        ST_BAD_OFFSET = 4'd9
    } t_status;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status     parse_status;
        logic [7:0]  hop_limit;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        t_pos        tcp_start;
        logic [15:0] segment_length;
        logic [15:0] payload_length;
    } t_out_item;

endpackage

`default_nettype wire

### hdl/ipv6_tcp_header_locator.sv
// ----------------------------------------------------------------------------
// IPv6 TCP header locator
// Parses an IPv6 packet byte by byte and reports where its TCP header lies.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one packet
//   byte per transaction, in wire order, with last_byte set on the final one.
//   Output channel (o_out_valid / i_out_stall / o_out_item) carries one
//   result transaction per packet: status, hop limit, addresses, TCP start,
//   segment length and payload length.
//   Throughput: one byte per cycle while o_in_stall is low, set by the single
//   parser step between the input register and the result register.
//   Result path: a taken final byte passes from the input register into the
//   result register, held back only while an earlier result is still waiting.
//   Reset clears the input register, the result register and all packet
//   state; the first byte after reset starts a new packet.
//   While the receiver stalls, bytes keep flowing until a final byte meets
//   a result that is still waiting; only then is o_in_stall raised.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ipv6_tcp_header_locator_defines.svh"

module ipv6_tcp_header_locator #(
    parameter int COUNT_BITS = 17
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire i6tcp_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output i6tcp_pkg::t_out_item   o_out_item
);

    logic                  r_s1_valid;
    i6tcp_pkg::t_in_item   r_s1;
    logic                  r_out_valid;
    i6tcp_pkg::t_out_item  r_out;

    logic                  w_s1_go;
    logic                  w_in_take;
    i6tcp_pkg::t_out_item  w_result;

    // Advance the held byte unless its result has nowhere to go
    assign w_s1_go    = r_s1_valid &&
                        (!r_s1.last_byte || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s1_go;
    assign w_in_take  = i_in_valid && !o_in_stall;

    i6tcp_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_s1_go),
        .i_item   (r_s1),
        .o_result (w_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1 <= i_in_item;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && r_s1.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && r_s1.last_byte) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Checks
    `I6TCP_ASSERT_IMPLY(a_stall_needs_byte, o_in_stall, r_s1_valid && r_s1.last_byte && r_out_valid, "input stalled without a blocked final byte")
    `I6TCP_ASSERT_NEXT(a_final_loads_result, w_s1_go && r_s1.last_byte, r_out_valid && (r_out == $past(w_result)), "final byte did not load its result")
    `I6TCP_ASSERT_IMPLY(a_error_fields_zero, r_out_valid && (r_out.parse_status != i6tcp_pkg::ST_OK), (r_out.tcp_start == '0) && (r_out.segment_length == 16'd0) && (r_out.payload_length == 16'd0), "error result carries TCP fields")
    `I6TCP_ASSERT_IMPLY(a_ok_fields_sane, r_out_valid && (r_out.parse_status == i6tcp_pkg::ST_OK), (r_out.tcp_start >= i6tcp_pkg::t_pos'(i6tcp_pkg::FIXED_HDR_BYTES)) && (r_out.payload_length <= r_out.segment_length), "ok result with impossible TCP fields")

endmodule

`default_nettype wire

### hdl/i6tcp_parser.sv
// ----------------------------------------------------------------------------
// IPv6 TCP header locator: byte parser
// Holds the per-packet state, updates it for one byte per step and forms
// the result transaction that the marked final byte releases.
// ----------------------------------------------------------------------------
`default_nettype none

module i6tcp_parser #(
    parameter int COUNT_BITS = 17
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_step,
    input  wire i6tcp_pkg::t_in_item i_item,
    output i6tcp_pkg::t_out_item   o_result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WALK,
        PH_DONE
    } t_phase;

    typedef logic [COUNT_BITS-1:0] t_count;

    t_count               r_byte_count, n_byte_count;
    i6tcp_pkg::t_pos      r_total_length, n_total_length;
    i6tcp_pkg::t_pos      r_header_start, n_header_start;
    logic [7:0]           r_header_type, n_header_type;
    i6tcp_pkg::t_ext      r_header_extent, n_header_extent;
    logic [7:0]           r_frag_high, n_frag_high;
    i6tcp_pkg::t_status   r_walk_status, n_walk_status;
    logic                 r_tcp_found, n_tcp_found;
    logic [5:0]           r_tcp_bytes, n_tcp_bytes;
    logic [7:0]           r_hop_limit, n_hop_limit;
    logic [63:0]          r_src_high, n_src_high;
    logic [63:0]          r_src_low, n_src_low;
    logic [63:0]          r_dst_high, n_dst_high;
    logic [63:0]          r_dst_low, n_dst_low;
    t_phase               r_phase, n_phase;
    logic [7:0]           r_pending_type, n_pending_type;

    logic [7:0]           w_byte;
    t_count               w_pos;
    t_count               w_rel;
    i6tcp_pkg::t_pos      w_room;
    logic                 w_in_header;
    i6tcp_pkg::t_ext      w_ext_len;
    logic                 w_do_enter;
    logic [7:0]           w_enter_type;
    i6tcp_pkg::t_pos      w_enter_room;
    i6tcp_pkg::t_ext      w_adv_ext;
    i6tcp_pkg::t_status   w_status;
    logic                 w_ok;

    assign w_byte = i_item.packet_byte;
    assign w_pos  = r_byte_count;
    assign w_room = r_total_length - r_header_start;
    assign w_rel  = w_pos - t_count'(r_header_start);

    assign w_in_header = (r_phase == PH_WALK) &&
                         (w_pos >= t_count'(r_header_start)) &&
                         (w_pos < t_count'(r_total_length));

    // Extension span from its length byte
    always_comb begin
        if (r_header_type == i6tcp_pkg::NH_AUTH) begin
            w_ext_len = ({4'd0, w_byte} + i6tcp_pkg::t_ext'(2)) << 2;
        end else begin
            w_ext_len = ({4'd0, w_byte} + i6tcp_pkg::t_ext'(1)) << 3;
        end
    end

    // Next state for one byte
    always_comb begin
        n_byte_count    = r_byte_count;
        n_total_length  = r_total_length;
        n_header_start  = r_header_start;
        n_header_type   = r_header_type;
        n_header_extent = r_header_extent;
        n_frag_high     = r_frag_high;
        n_walk_status   = r_walk_status;
        n_tcp_found     = r_tcp_found;
        n_tcp_bytes     = r_tcp_bytes;
        n_hop_limit     = r_hop_limit;
        n_src_high      = r_src_high;
        n_src_low       = r_src_low;
        n_dst_high      = r_dst_high;
        n_dst_low       = r_dst_low;
        n_phase         = r_phase;
        n_pending_type  = r_pending_type;
        w_do_enter      = 1'b0;
        w_enter_type    = w_byte;
        w_enter_room    = w_room;
        w_adv_ext       = r_header_extent;

        // Capture the fixed header
        if (w_pos == t_count'(i6tcp_pkg::POS_LEN_HI)) begin
            n_total_length = {1'b0, w_byte, 8'd0};
        end else if (w_pos == t_count'(i6tcp_pkg::POS_LEN_LO)) begin
            n_total_length = i6tcp_pkg::t_pos'(i6tcp_pkg::FIXED_HDR_BYTES) +
                             (r_total_length | {9'd0, w_byte});
        end else if (w_pos == t_count'(i6tcp_pkg::POS_NEXT_HDR)) begin
            n_header_type = w_byte;
            n_phase       = PH_WALK;
            w_do_enter    = 1'b1;
            w_enter_type  = w_byte;
            w_enter_room  = w_room;
        end else if (w_pos == t_count'(i6tcp_pkg::POS_HOP_LIMIT)) begin
            n_hop_limit = w_byte;
        end else if (w_pos < t_count'(i6tcp_pkg::POS_DST_FIRST) &&
                     w_pos >= t_count'(i6tcp_pkg::POS_SRC_FIRST)) begin
            if (w_pos < t_count'(i6tcp_pkg::POS_SRC_SPLIT)) begin
                n_src_high = {r_src_high[55:0], w_byte};
            end else begin
                n_src_low = {r_src_low[55:0], w_byte};
            end
        end else if (w_pos < t_count'(i6tcp_pkg::FIXED_HDR_BYTES) &&
                     w_pos >= t_count'(i6tcp_pkg::POS_DST_FIRST)) begin
            if (w_pos < t_count'(i6tcp_pkg::POS_DST_SPLIT)) begin
                n_dst_high = {r_dst_high[55:0], w_byte};
            end else begin
                n_dst_low = {r_dst_low[55:0], w_byte};
            end
        end else if (w_in_header) begin
            // Walk the current header
            case (r_header_type)
                i6tcp_pkg::NH_HOP_BY_HOP, i6tcp_pkg::NH_ROUTING,
                i6tcp_pkg::NH_DEST_OPTS, i6tcp_pkg::NH_AUTH: begin
                    if (w_rel == t_count'(i6tcp_pkg::REL_NEXT_HDR)) begin
                        n_pending_type = w_byte;
                    end else if (w_rel == t_count'(i6tcp_pkg::REL_LENGTH)) begin
                        n_header_extent = w_ext_len;
                        w_adv_ext       = w_ext_len;
                        if (w_room < i6tcp_pkg::t_pos'(w_ext_len)) begin
                            n_walk_status = (r_header_type == i6tcp_pkg::NH_AUTH) ?
                                            i6tcp_pkg::ST_AUTH_LEN : i6tcp_pkg::ST_EXT_LEN;
                            n_phase       = PH_DONE;
                        end else begin
                            w_do_enter = 1'b1;
                        end
                    end
                end
                i6tcp_pkg::NH_FRAGMENT: begin
                    if (w_rel == t_count'(i6tcp_pkg::REL_NEXT_HDR)) begin
                        n_pending_type = w_byte;
                    end else if (w_rel == t_count'(i6tcp_pkg::REL_FRAG_HI)) begin
                        n_frag_high = w_byte;
                    end else if (w_rel == t_count'(i6tcp_pkg::REL_FRAG_LO)) begin
                        if (({r_frag_high, w_byte} & i6tcp_pkg::FRAG_REFUSE_MASK)
                                != 16'd0) begin
                            n_walk_status = i6tcp_pkg::ST_FRAGMENTED;
                            n_phase       = PH_DONE;
                        end else begin
                            w_do_enter = 1'b1;
                        end
                    end
                end
                i6tcp_pkg::NH_TCP: begin
                    if (w_rel == t_count'(i6tcp_pkg::REL_TCP_OFFSET)) begin
                        n_tcp_bytes = {w_byte[7:4], 2'b00};
                        if ({w_byte[7:4], 2'b00} < 6'(i6tcp_pkg::TCP_MIN_BYTES) ||
                            w_room < i6tcp_pkg::t_pos'({w_byte[7:4], 2'b00})) begin
                            n_walk_status = i6tcp_pkg::ST_BAD_OFFSET;
                        end else begin
                            n_tcp_found   = 1'b1;
                            n_walk_status = i6tcp_pkg::ST_OK;
                        end
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase

            // Advance to the next header in the chain
            if (w_do_enter) begin
                n_header_start = r_header_start + i6tcp_pkg::t_pos'(w_adv_ext);
                n_header_type  = r_pending_type;
                w_enter_type   = r_pending_type;
                w_enter_room   = w_room - i6tcp_pkg::t_pos'(w_adv_ext);
            end
        end

        // Check that the header just entered fits
        if (w_do_enter) begin
            case (w_enter_type)
                i6tcp_pkg::NH_TCP: begin
                    if (w_enter_room < i6tcp_pkg::t_pos'(i6tcp_pkg::TCP_MIN_BYTES)) begin
                        n_walk_status = i6tcp_pkg::ST_TCP_SHORT;
                        n_phase       = PH_DONE;
                    end else begin
                        n_header_extent = i6tcp_pkg::t_ext'(i6tcp_pkg::TCP_MIN_BYTES);
                    end
                end
                i6tcp_pkg::NH_HOP_BY_HOP, i6tcp_pkg::NH_ROUTING,
                i6tcp_pkg::NH_DEST_OPTS: begin
                    if (w_enter_room < i6tcp_pkg::t_pos'(i6tcp_pkg::EXT_MIN_BYTES)) begin
                        n_walk_status = i6tcp_pkg::ST_EXT_LEN;
                        n_phase       = PH_DONE;
                    end
                end
                i6tcp_pkg::NH_FRAGMENT: begin
                    if (w_enter_room < i6tcp_pkg::t_pos'(i6tcp_pkg::FRAG_BYTES)) begin
                        n_walk_status = i6tcp_pkg::ST_FRAG_LEN;
                        n_phase       = PH_DONE;
                    end else begin
                        n_header_extent = i6tcp_pkg::t_ext'(i6tcp_pkg::FRAG_BYTES);
                    end
                end
                i6tcp_pkg::NH_AUTH: begin
                    if (w_enter_room < i6tcp_pkg::t_pos'(i6tcp_pkg::EXT_MIN_BYTES)) begin
                        n_walk_status = i6tcp_pkg::ST_AUTH_LEN;
                        n_phase       = PH_DONE;
                    end
                end
                default: begin
                    n_walk_status = i6tcp_pkg::ST_NOT_TCP;
                    n_phase       = PH_DONE;
                end
            endcase
        end

        // Saturate the byte counter
        if (r_byte_count != {COUNT_BITS{1'b1}}) begin
            n_byte_count = r_byte_count + t_count'(1);
        end
    end

    // Final status: short, then truncated, then the walk's own code
    always_comb begin
        if (n_byte_count < t_count'(i6tcp_pkg::FIXED_HDR_BYTES)) begin
            w_status = i6tcp_pkg::ST_SHORT;
        end else if (t_count'(n_total_length) > n_byte_count) begin
            w_status = i6tcp_pkg::ST_TRUNCATED;
        end else if (n_phase != PH_DONE) begin
            w_status = i6tcp_pkg::ST_TRUNCATED;
        end else begin
            w_status = n_walk_status;
        end
    end

    assign w_ok = (w_status == i6tcp_pkg::ST_OK) && n_tcp_found;

    // Form the result; the header start is stable once TCP is found
    always_comb begin
        o_result.parse_status   = w_status;
        o_result.hop_limit      = n_hop_limit;
        o_result.source_high    = n_src_high;
        o_result.source_low     = n_src_low;
        o_result.dest_high      = n_dst_high;
        o_result.dest_low       = n_dst_low;
        o_result.tcp_start      = w_ok ? r_header_start : '0;
        o_result.segment_length = w_ok ? w_room[15:0] : 16'd0;
        o_result.payload_length = w_ok ? (w_room[15:0] - {10'd0, n_tcp_bytes}) : 16'd0;
    end

    // Hold packet state; clear it after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_byte_count    <= '0;
            r_total_length  <= '0;
            r_header_start  <= i6tcp_pkg::t_pos'(i6tcp_pkg::FIXED_HDR_BYTES);
            r_header_type   <= i6tcp_pkg::NH_HOP_BY_HOP;
            r_header_extent <= '0;
            r_frag_high     <= '0;
            r_walk_status   <= i6tcp_pkg::ST_OK;
            r_tcp_found     <= 1'b0;
            r_tcp_bytes     <= '0;
            r_hop_limit     <= '0;
            r_src_high      <= '0;
            r_src_low       <= '0;
            r_dst_high      <= '0;
            r_dst_low       <= '0;
            r_phase         <= PH_IDLE;
            r_pending_type  <= '0;
        end else if (i_step) begin
            r_byte_count    <= n_byte_count;
            r_total_length  <= n_total_length;
            r_header_start  <= n_header_start;
            r_header_type   <= n_header_type;
            r_header_extent <= n_header_extent;
            r_frag_high     <= n_frag_high;
            r_walk_status   <= n_walk_status;
            r_tcp_found     <= n_tcp_found;
            r_tcp_bytes     <= n_tcp_bytes;
            r_hop_limit     <= n_hop_limit;
            r_src_high      <= n_src_high;
            r_src_low       <= n_src_low;
            r_dst_high      <= n_dst_high;
            r_dst_low       <= n_dst_low;
            r_phase         <= n_phase;
            r_pending_type  <= n_pending_type;
        end
    end

endmodule

`default_nettype wire

### sim/tb_ipv6_tcp_header_locator.sv
// ----------------------------------------------------------------------------
// IPv6 TCP header locator testbench
// Streams IPv6 packets byte by byte into the locator. A byte-level tracker
// of the extension-header walk predicts each packet's report. Every report
// the block returns is compared field by field with the oldest prediction.
// A directed set of packets comes first, then a mix of well-formed chains,
// damaged packets and noise. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_ipv6_tcp_header_locator;

    timeunit 1ns;
    timeprecision 1ps;

    import i6tcp_pkg::*;

    localparam int         CLK_HALF      = 5;
    localparam int         RESET_CYCLES  = 5;
    localparam int         COUNT_BITS    = 17;
    localparam int         CNT_MAX       = (1 << COUNT_BITS) - 1;
    localparam int         MAX_GAP       = 40;
    localparam int         MAX_STALL     = 40;
    localparam int         DRAIN_CYCLES  = 20;
    localparam int         TOTAL_BYTES   = 1850;
    localparam logic [7:0] NH_UDP        = 8'd17;

    typedef enum logic [1:0] {
        WALK_IDLE,
        WALK_BUSY,
        WALK_OVER
    } t_walk;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_item;

    // Stimulus, predictions and bookkeeping
    t_in_item   byte_queue[$];
    t_out_item  awaited_reports[$];
    t_out_item  want;
    logic [7:0] pkt_bytes[$];
    logic [7:0] chain_types[$];
    int         nh_pos[$];
    int         len_pos[$];
    int         doff_pos;
    int         frag_pos;
    int         n_items = 0;
    int         n_pkts = 0;
    int         mismatches = 0;
    int         gap_left = 0;
    int         burst_left = 0;
    int         stall_left = 0;
    int         calm_left = 0;
    bit         in_taken = 1'b0;
    longint     cycle_count = 0;
    longint     cycle_limit = 64'd100_000_000;

    // Tracker state for the packet in flight
    int          cnt_seen;
    int          pkt_total;
    int          hdr_at;
    int          hdr_span;
    int          tcp_hlen;
    logic [7:0]  hdr_kind;
    logic [7:0]  next_kind;
    logic [7:0]  frag_hi_byte;
    t_status     chain_code;
    bit          tcp_seen;
    t_walk       walk_phase;
    logic [7:0]  hop_cap;
    logic [63:0] src_cap[2];
    logic [63:0] dst_cap[2];

    ipv6_tcp_header_locator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Header walk tracker
    // ------------------------------------------------------------------
    function automatic void clear_tracker();
        cnt_seen     = 0;
        pkt_total    = 0;
        hdr_at       = FIXED_HDR_BYTES;
        hdr_kind     = NH_HOP_BY_HOP;
        hdr_span     = 0;
        frag_hi_byte = 8'd0;
        chain_code   = ST_OK;
        tcp_seen     = 1'b0;
        tcp_hlen     = 0;
        hop_cap      = 8'd0;
        src_cap[0]   = 64'd0;
        src_cap[1]   = 64'd0;
        dst_cap[0]   = 64'd0;
        dst_cap[1]   = 64'd0;
        walk_phase   = WALK_IDLE;
        next_kind    = 8'd0;
    endfunction

    function automatic void end_chain(t_status code);
        chain_code = code;
        walk_phase = WALK_OVER;
    endfunction

    // Check the room left for the header that starts at hdr_at
    function automatic void open_header();
        int room;
        room = pkt_total - hdr_at;
        case (hdr_kind)
            NH_TCP: begin
                if (room < TCP_MIN_BYTES) end_chain(ST_TCP_SHORT);
                else hdr_span = TCP_MIN_BYTES;
            end
            NH_HOP_BY_HOP, NH_ROUTING, NH_DEST_OPTS: begin
                if (room < EXT_MIN_BYTES) end_chain(ST_EXT_LEN);
            end
            NH_FRAGMENT: begin
                if (room < FRAG_BYTES) end_chain(ST_FRAG_LEN);
                else hdr_span = FRAG_BYTES;
            end
            NH_AUTH: begin
                if (room < EXT_MIN_BYTES) end_chain(ST_AUTH_LEN);
            end
            default: begin
                end_chain(ST_NOT_TCP);
            end
        endcase
    endfunction

    function automatic void step_header();
        hdr_at   = (hdr_at + hdr_span) & CNT_MAX;
        hdr_kind = next_kind;
        open_header();
    endfunction

    function automatic void walk_chain_byte(int pos, logic [7:0] b);
        int rel;
        if (walk_phase != WALK_BUSY || pos < hdr_at || pos >= pkt_total) return;
        rel = pos - hdr_at;
        case (hdr_kind)
            NH_HOP_BY_HOP, NH_ROUTING, NH_DEST_OPTS, NH_AUTH: begin
                if (rel == REL_NEXT_HDR) begin
                    next_kind = b;
                end else if (rel == REL_LENGTH) begin
                    if (hdr_kind == NH_AUTH) hdr_span = (int'(b) + 2) * 4;
                    else hdr_span = (int'(b) + 1) * 8;
                    if (pkt_total - hdr_at < hdr_span) begin
                        if (hdr_kind == NH_AUTH) end_chain(ST_AUTH_LEN);
                        else end_chain(ST_EXT_LEN);
                    end else begin
                        step_header();
                    end
                end
            end
            NH_FRAGMENT: begin
                if (rel == REL_NEXT_HDR) begin
                    next_kind = b;
                end else if (rel == REL_FRAG_HI) begin
                    frag_hi_byte = b;
                end else if (rel == REL_FRAG_LO) begin
                    if (({frag_hi_byte, b} & FRAG_REFUSE_MASK) != 16'd0) end_chain(ST_FRAGMENTED);
                    else step_header();
                end
            end
            NH_TCP: begin
                if (rel == REL_TCP_OFFSET) begin
                    tcp_hlen = int'(b[7:4]) * 4;
                    if (tcp_hlen < TCP_MIN_BYTES || pkt_total - hdr_at < tcp_hlen) begin
                        end_chain(ST_BAD_OFFSET);
                    end else begin
                        tcp_seen = 1'b1;
                        end_chain(ST_OK);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Advance the tracker by one accepted byte; on the final byte queue the report
    function automatic void track_byte(logic [7:0] b, logic last);
        int        pos;
        int        k;
        int        seg;
        t_status   st;
        t_out_item rep;
        pos = cnt_seen;
        if (pos == POS_LEN_HI) begin
            pkt_total = int'(b) << 8;
        end else if (pos == POS_LEN_LO) begin
            pkt_total = FIXED_HDR_BYTES + (pkt_total | int'(b));
        end else if (pos == POS_NEXT_HDR) begin
            hdr_kind   = b;
            walk_phase = WALK_BUSY;
            open_header();
        end else if (pos == POS_HOP_LIMIT) begin
            hop_cap = b;
        end else if (pos >= POS_SRC_FIRST && pos < POS_DST_FIRST) begin
            k = (pos < POS_SRC_SPLIT) ? 0 : 1;
            src_cap[k] = {src_cap[k][55:0], b};
        end else if (pos >= POS_DST_FIRST && pos < FIXED_HDR_BYTES) begin
            k = (pos < POS_DST_SPLIT) ? 0 : 1;
            dst_cap[k] = {dst_cap[k][55:0], b};
        end else if (pos >= FIXED_HDR_BYTES) begin
            walk_chain_byte(pos, b);
        end
        if (cnt_seen < CNT_MAX) cnt_seen++;
        if (!last) return;

        // Short wins over truncated, truncated over the walk's own code
        if (cnt_seen < FIXED_HDR_BYTES) st = ST_SHORT;
        else if (pkt_total > cnt_seen) st = ST_TRUNCATED;
        else if (walk_phase != WALK_OVER) st = ST_TRUNCATED;
        else st = chain_code;

        rep = '0;
        rep.parse_status = st;
        rep.hop_limit    = hop_cap;
        rep.source_high  = src_cap[0];
        rep.source_low   = src_cap[1];
        rep.dest_high    = dst_cap[0];
        rep.dest_low     = dst_cap[1];
        if (st == ST_OK && tcp_seen) begin
            seg = pkt_total - hdr_at;
            rep.tcp_start      = t_pos'(hdr_at);
            rep.segment_length = 16'(seg);
            rep.payload_length = 16'(seg - tcp_hlen);
        end
        awaited_reports.push_back(rep);
        clear_tracker();
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_val, logic [63:0] act);
        if (act !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Packet construction
    // ------------------------------------------------------------------
    function automatic void set_length(int n);
        pkt_bytes[POS_LEN_HI] = 8'(n >> 8);
        pkt_bytes[POS_LEN_LO] = 8'(n);
    endfunction

    function automatic void cut_to(int n);
        while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
    endfunction

    function automatic logic [7:0] pick_ext();
        case ($urandom_range(0, 4))
            0:       return NH_HOP_BY_HOP;
            1:       return NH_ROUTING;
            2:       return NH_FRAGMENT;
            3:       return NH_AUTH;
            default: return NH_DEST_OPTS;
        endcase
    endfunction

    // Build a packet through chain_types, then TCP with the given data offset
    function automatic void build_packet(int doff, int data_len, int trail);
        int         elen;
        int         span;
        int         hb;
        logic [7:0] nxt;
        pkt_bytes = {};
        nh_pos    = {};
        len_pos   = {};
        frag_pos  = -1;
        repeat (4) pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(8'd0);
        pkt_bytes.push_back(8'd0);
        nh_pos.push_back(POS_NEXT_HDR);
        pkt_bytes.push_back((chain_types.size() > 0) ? chain_types[0] : NH_TCP);
        repeat (33) pkt_bytes.push_back(8'($urandom));
        for (int i = 0; i < chain_types.size(); i++) begin
            nxt = (i + 1 < chain_types.size()) ? chain_types[i + 1] : NH_TCP;
            nh_pos.push_back(pkt_bytes.size());
            pkt_bytes.push_back(nxt);
            if (chain_types[i] == NH_FRAGMENT) begin
                pkt_bytes.push_back(8'($urandom));
                frag_pos = pkt_bytes.size();
                pkt_bytes.push_back(8'd0);
                pkt_bytes.push_back(8'($urandom) & 8'h06);
                repeat (4) pkt_bytes.push_back(8'($urandom));
            end else begin
                if (chain_types[i] == NH_AUTH) begin
                    elen = $urandom_range(0, 3);
                    span = (elen + 2) * 4;
                end else begin
                    elen = $urandom_range(0, 2);
                    span = (elen + 1) * 8;
                end
                len_pos.push_back(pkt_bytes.size());
                pkt_bytes.push_back(8'(elen));
                repeat (span - 2) pkt_bytes.push_back(8'($urandom));
            end
        end
        hb = (doff * 4 < TCP_MIN_BYTES) ? TCP_MIN_BYTES : doff * 4;
        for (int i = 0; i < hb; i++) begin
            if (i == REL_TCP_OFFSET) begin
                doff_pos = pkt_bytes.size();
                pkt_bytes.push_back({4'(doff), 4'($urandom)});
            end else begin
                pkt_bytes.push_back(8'($urandom));
            end
        end
        repeat (data_len) pkt_bytes.push_back(8'($urandom));
        set_length(pkt_bytes.size() - FIXED_HDR_BYTES);
        repeat (trail) pkt_bytes.push_back(8'($urandom));
    endfunction

    function automatic void send_packet();
        for (int i = 0; i < pkt_bytes.size(); i++)
            byte_queue.push_back('{packet_byte: pkt_bytes[i], last_byte: i == pkt_bytes.size() - 1});
        n_items += pkt_bytes.size();
        n_pkts++;
    endfunction

    // Damage one aspect of the packet just built
    function automatic void damage_packet();
        int n;
        int delta;
        n = pkt_bytes.size();
        case ($urandom_range(0, 6))
            0: begin
                if ($urandom_range(0, 1) == 0) cut_to($urandom_range(1, n - 1));
                else cut_to($urandom_range((n > 9) ? n - 8 : 1, n - 1));
            end
            1: begin
                delta = $urandom_range(0, 16) - 8;
                if ($urandom_range(0, 1) == 0) set_length($urandom_range(0, 65535));
                else if (n - FIXED_HDR_BYTES + delta < 0) set_length(0);
                else set_length(n - FIXED_HDR_BYTES + delta);
            end
            2: pkt_bytes[nh_pos[$urandom_range(0, nh_pos.size() - 1)]] = 8'($urandom);
            3: pkt_bytes[doff_pos] = {4'($urandom), pkt_bytes[doff_pos][3:0]};
            5: begin
                if (len_pos.size() > 0)
                    pkt_bytes[len_pos[$urandom_range(0, len_pos.size() - 1)]] =
                        8'($urandom_range(8, 255));
                else
                    pkt_bytes[$urandom_range(0, n - 1)] = 8'($urandom);
            end
            6: begin
                if (frag_pos >= 0) begin
                    pkt_bytes[frag_pos]     = 8'($urandom);
                    pkt_bytes[frag_pos + 1] = 8'($urandom);
                end else begin
                    pkt_bytes[$urandom_range(0, n - 1)] = 8'($urandom);
                end
            end
            default: pkt_bytes[$urandom_range(0, n - 1)] = 8'($urandom);
        endcase
    endfunction

    // Idle between input transactions: mostly none or short, a few long,
    // with the odd burst of back-to-back bytes
    function automatic int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 200);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, MAX_GAP);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int r;
        int n_ext;
        int doff;

        // Capture cut to one byte and to one byte under the fixed header
        chain_types = {};
        build_packet(5, 0, 0);
        cut_to(1);
        send_packet();
        build_packet(5, 0, 0);
        cut_to(FIXED_HDR_BYTES - 1);
        send_packet();

        // Fixed header only, TCP named but no room for it
        build_packet(5, 0, 0);
        cut_to(FIXED_HDR_BYTES);
        set_length(0);
        send_packet();

        // Largest payload length with only the fixed header captured
        build_packet(5, 0, 0);
        cut_to(FIXED_HDR_BYTES);
        set_length(16'hFFFF);
        send_packet();

        // Plain TCP at both data-offset extremes, one with trailing bytes
        build_packet(5, 0, 0);
        send_packet();
        build_packet(15, 7, 5);
        send_packet();

        // Data offset under the minimum, and beyond the segment
        build_packet(4, 3, 0);
        send_packet();
        build_packet(5, 0, 0);
        pkt_bytes[doff_pos] = {4'hF, pkt_bytes[doff_pos][3:0]};
        send_packet();

        // Every extension type in one chain
        chain_types = {NH_HOP_BY_HOP, NH_ROUTING, NH_DEST_OPTS, NH_AUTH, NH_FRAGMENT};
        build_packet(6, 9, 0);
        send_packet();

        // Fragment with nonzero offset, then with more-fragments set
        chain_types = {NH_FRAGMENT};
        build_packet(5, 4, 0);
        pkt_bytes[frag_pos] = 8'h01;
        send_packet();
        build_packet(5, 4, 0);
        pkt_bytes[frag_pos + 1] = pkt_bytes[frag_pos + 1] | 8'h01;
        send_packet();

        // Extension and AH lengths running past the packet
        chain_types = {NH_HOP_BY_HOP};
        build_packet(5, 0, 0);
        pkt_bytes[len_pos[0]] = 8'hFF;
        send_packet();
        chain_types = {NH_AUTH};
        build_packet(5, 0, 0);
        pkt_bytes[len_pos[0]] = 8'hFF;
        send_packet();

        // Too little room to read an extension, AH or fragment header
        chain_types = {};
        build_packet(5, 0, 0);
        pkt_bytes[POS_NEXT_HDR] = NH_HOP_BY_HOP;
        set_length(1);
        cut_to(FIXED_HDR_BYTES + 1);
        send_packet();
        build_packet(5, 0, 0);
        pkt_bytes[POS_NEXT_HDR] = NH_AUTH;
        set_length(1);
        cut_to(FIXED_HDR_BYTES + 1);
        send_packet();
        build_packet(5, 0, 0);
        pkt_bytes[POS_NEXT_HDR] = NH_FRAGMENT;
        set_length(4);
        cut_to(FIXED_HDR_BYTES + 4);
        send_packet();

        // Upper layer other than TCP
        build_packet(5, 0, 0);
        pkt_bytes[POS_NEXT_HDR] = NH_UDP;
        send_packet();

        // TCP left with too little room after an extension
        chain_types = {NH_DEST_OPTS};
        build_packet(5, 0, 0);
        cut_to(doff_pos - REL_TCP_OFFSET + 10);
        set_length(pkt_bytes.size() - FIXED_HDR_BYTES);
        send_packet();

        // All-ones and all-zeros packets
        pkt_bytes = {};
        repeat (64) pkt_bytes.push_back(8'hFF);
        send_packet();
        pkt_bytes = {};
        repeat (FIXED_HDR_BYTES) pkt_bytes.push_back(8'h00);
        send_packet();

        // Random part: mostly well-formed chains, some damaged, some noise
        while (n_items < TOTAL_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                pkt_bytes = {};
                repeat ($urandom_range(1, 80)) pkt_bytes.push_back(8'($urandom));
            end else begin
                chain_types = {};
                n_ext = $urandom_range(0, 99);
                n_ext = (n_ext < 40) ? 0 : (n_ext < 70) ? 1 : (n_ext < 90) ? 2 : 3;
                repeat (n_ext) chain_types.push_back(pick_ext());
                doff = ($urandom_range(0, 99) < 70) ? $urandom_range(5, 8) : $urandom_range(5, 15);
                build_packet(doff, $urandom_range(0, 24),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 0);
                if (r < 30) damage_packet();
            end
            send_packet();
        end

        cycle_limit = 4 * (longint'(n_items) * (MAX_GAP + 2) +
                           longint'(n_pkts) * (MAX_STALL + 10)) + 10000;

        // Hold reset, then release
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all bytes taken, all reports back, then the block's latency
        while (byte_queue.size() != 0 || i_in_valid || awaited_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_reports.size() != 0) begin
            $error("%0d reports never arrived", awaited_reports.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial clear_tracker();

    // ------------------------------------------------------------------
    // Input driver: present the next byte, hold it while stalled
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // hold the stalled transaction
        end else if (gap_left > 0) begin
            gap_left--;
            i_in_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
            i_in_item  <= byte_queue.pop_front();
            i_in_valid <= 1'b1;
            gap_left   = next_gap();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Output stall: mostly short, a few long, with calm stretches
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (calm_left > 0) begin
            calm_left--;
            i_out_stall <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: begin
                    stall_left = $urandom_range(0, 2);
                    i_out_stall <= 1'b1;
                end
                4: begin
                    stall_left = $urandom_range(3, MAX_STALL - 1);
                    i_out_stall <= 1'b1;
                end
                5: begin
                    calm_left = $urandom_range(50, 300);
                    i_out_stall <= 1'b0;
                end
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check reports, then track accepted bytes
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_reports.size() == 0) begin
                    $error("unexpected report transaction, status %0d",
                           o_out_item.parse_status);
                    mismatches++;
                end else begin
                    want = awaited_reports.pop_front();
                    check_field("parse_status", want.parse_status, o_out_item.parse_status);
                    check_field("hop_limit", want.hop_limit, o_out_item.hop_limit);
                    check_field("source_high", want.source_high, o_out_item.source_high);
                    check_field("source_low", want.source_low, o_out_item.source_low);
                    check_field("dest_high", want.dest_high, o_out_item.dest_high);
                    check_field("dest_low", want.dest_low, o_out_item.dest_low);
                    check_field("tcp_start", want.tcp_start, o_out_item.tcp_start);
                    check_field("segment_length", want.segment_length,
                                o_out_item.segment_length);
                    check_field("payload_length", want.payload_length,
                                o_out_item.payload_length);
                end
            end
            if (i_in_valid && !o_in_stall)
                track_byte(i_in_item.packet_byte, i_in_item.last_byte);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= cycle_limit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

### sim.f
+incdir+hdl
hdl/i6tcp_pkg.sv
hdl/i6tcp_parser.sv
hdl/ipv6_tcp_header_locator.sv
sim/tb_ipv6_tcp_header_locator.sv
